>>> rtl/dlr_pkg.sv
package dlr_pkg;

  // Coordinate and arithmetic widths.
  localparam int COORD_BITS = 9;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int STEP_BITS  = COORD_BITS + 1;
  localparam int COLOR_BITS = 16;
  localparam int PAT_BITS   = 8;
  localparam int POS_BITS   = 3;

  // Item kinds on the input channel.
  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  // Step direction codes of one axis.
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_POS  = 2'd1;
  localparam logic [1:0] DIR_NEG  = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_FORE    = 2'd0;
  localparam logic [1:0] REG_BACK    = 2'd1;
  localparam logic [1:0] REG_PATTERN = 2'd2;

  // Reset values of the registers.
  localparam logic [COLOR_BITS-1:0] FORE_RESET    = 16'hFFFF;
  localparam logic [COLOR_BITS-1:0] BACK_RESET    = 16'h0000;
  localparam logic [PAT_BITS-1:0]   PATTERN_RESET = 8'hFF;

  // Pattern position used first on every line.
  localparam logic [POS_BITS-1:0] FIRST_POS = 3'd7;

  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pix_x;
    logic [COORD_BITS-1:0] pix_y;
    logic [COLOR_BITS-1:0] pix_color;
    logic                  last;
  } out_item_t;

  // Command handed from the front end to the pixel engine.
  typedef struct packed {
    logic                  start;
    logic                  last;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic [1:0]            dir_x;
    logic [1:0]            dir_y;
    logic [COORD_BITS-1:0] span;
  } cmd_t;

  // Settings seen by the pixel engine.
  typedef struct packed {
    logic [COLOR_BITS-1:0] fore;
    logic [COLOR_BITS-1:0] back;
    logic [PAT_BITS-1:0]   pattern;
  } cfg_t;

endpackage

>>> rtl/dashed_line_rasterizer.sv
// Channel   | Ports                               | Accepted when
// ----------+-------------------------------------+-------------------------------
// input     | in_push, in_full, in_item           | in_push && !in_full
// result    | out_pop, out_empty, out_item        | out_pop && !out_empty
// settings  | psel, penable, pwrite, paddr, pwdata | psel && penable && pwrite
//
// One item is taken per clock while in_full is low, and an unstalled stream
// gives one pixel per cycle. A command passes through the two-entry command
// queue and then the engine, which registers the pixel as it takes the command.
// Advances with no line in progress are dropped at the front and give no pixel.
// A stalled result side fills the queue, then in_full rises. Reset is
// synchronous and clears the queue, the line tracking and the result valid flag.
module dashed_line_rasterizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  dlr_pkg::in_item_t  in_item,
  output logic               in_full,
  output dlr_pkg::out_item_t out_item,
  output logic               out_empty,
  input  logic               out_pop,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import dlr_pkg::*;

  logic                  q_push, q_full, q_empty, cmd_take;
  cmd_t                  q_cmd, head_cmd;
  cfg_t                  cfg;
  logic [COLOR_BITS-1:0] fore_r, back_r;
  logic [PAT_BITS-1:0]   pattern_r;
  logic                  cfg_write;
  logic [1:0]            reg_idx;

  // Settings registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fore_r    <= FORE_RESET;
      back_r    <= BACK_RESET;
      pattern_r <= PATTERN_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_FORE:    fore_r    <= pwdata[COLOR_BITS-1:0];
        REG_BACK:    back_r    <= pwdata[COLOR_BITS-1:0];
        REG_PATTERN: pattern_r <= pwdata[PAT_BITS-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FORE:    prdata = {16'd0, fore_r};
      REG_BACK:    prdata = {16'd0, back_r};
      REG_PATTERN: prdata = {24'd0, pattern_r};
      default:     prdata = '0;
    endcase
  end

  assign cfg.fore    = fore_r;
  assign cfg.back    = back_r;
  assign cfg.pattern = pattern_r;

  dlr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .q_push  (q_push),
    .q_cmd   (q_cmd),
    .q_full  (q_full)
  );

  dlr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (cmd_take),
    .head     (head_cmd),
    .empty    (q_empty)
  );

  dlr_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (head_cmd),
    .cmd_valid (!q_empty),
    .cmd_take  (cmd_take),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

`ifndef SYNTHESIS
  // Every accepted start reaches the queue.
  a_start_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full && in_item.kind == KIND_START |=> !q_empty)
    else $error("start item was not queued");

  // The engine only takes commands that are there.
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> !q_empty)
    else $error("engine took from an empty queue");

  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command queue overflow");

  // After reset no result is shown.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result shown after reset");
`endif

endmodule

>>> rtl/dlr_front.sv
module dlr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  dlr_pkg::in_item_t in_item,
  output logic              in_full,
  output logic              q_push,
  output dlr_pkg::cmd_t     q_cmd,
  input  logic              q_full
);
  import dlr_pkg::*;

  logic                 active_r, active_nxt;
  logic [STEP_BITS-1:0] steps_left_r, steps_left_nxt;
  logic                 accept;
  logic [COORD_BITS-1:0] adx, ady, span;
  logic [1:0]            dir_x, dir_y;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  // Deltas and directions of a new line.
  always_comb begin
    if (in_item.x_end > in_item.x_start) begin
      adx   = in_item.x_end - in_item.x_start;
      dir_x = DIR_POS;
    end else if (in_item.x_end == in_item.x_start) begin
      adx   = '0;
      dir_x = DIR_NONE;
    end else begin
      adx   = in_item.x_start - in_item.x_end;
      dir_x = DIR_NEG;
    end
    if (in_item.y_end > in_item.y_start) begin
      ady   = in_item.y_end - in_item.y_start;
      dir_y = DIR_POS;
    end else if (in_item.y_end == in_item.y_start) begin
      ady   = '0;
      dir_y = DIR_NONE;
    end else begin
      ady   = in_item.y_start - in_item.y_end;
      dir_y = DIR_NEG;
    end
    span = (adx > ady) ? adx : ady;
  end

  // Classify the item, keep the pixel count and flag the last pixel.
  always_comb begin
    active_nxt     = active_r;
    steps_left_nxt = steps_left_r;
    q_push         = 1'b0;
    q_cmd.start    = (in_item.kind == KIND_START);
    q_cmd.last     = 1'b0;
    q_cmd.x        = in_item.x_start;
    q_cmd.y        = in_item.y_start;
    q_cmd.adx      = adx;
    q_cmd.ady      = ady;
    q_cmd.dir_x    = dir_x;
    q_cmd.dir_y    = dir_y;
    q_cmd.span     = span;
    if (accept) begin
      if (in_item.kind == KIND_START) begin
        q_push         = 1'b1;
        active_nxt     = 1'b1;
        steps_left_nxt = {1'b0, span} + STEP_BITS'(1);
      end else if (active_r) begin
        q_push         = 1'b1;
        steps_left_nxt = steps_left_r - STEP_BITS'(1);
        if (steps_left_r == STEP_BITS'(1)) begin
          q_cmd.last = 1'b1;
          active_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      steps_left_r <= '0;
    end else begin
      active_r     <= active_nxt;
      steps_left_r <= steps_left_nxt;
    end
  end

endmodule

>>> rtl/dlr_fifo.sv
module dlr_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dlr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output dlr_pkg::cmd_t head,
  output logic          empty
);
  import dlr_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/dlr_engine.sv
module dlr_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  dlr_pkg::cfg_t      cfg,
  input  dlr_pkg::cmd_t      cmd,
  input  logic               cmd_valid,
  output logic               cmd_take,
  output dlr_pkg::out_item_t out_item,
  output logic               out_empty,
  input  logic               out_pop
);
  import dlr_pkg::*;

  logic [COORD_BITS-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [COORD_BITS-1:0] adx_r, ady_r, span_r;
  logic [1:0]            dir_x_r, dir_y_r;
  logic [ERR_BITS-1:0]   err_x_r, err_x_nxt, err_y_r, err_y_nxt;
  logic [ERR_BITS-1:0]   sum_x, sum_y;
  logic [POS_BITS-1:0]   pos_r;
  logic                  out_valid_r;
  out_item_t             out_r, out_nxt;
  logic                  pat_bit;

  // A command is taken whenever the result register is free or being emptied.
  assign cmd_take  = cmd_valid && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

  // One error step per axis: add the delta, fold back past the span.
  always_comb begin
    sum_x     = err_x_r + ERR_BITS'(adx_r);
    sum_y     = err_y_r + ERR_BITS'(ady_r);
    err_x_nxt = sum_x;
    err_y_nxt = sum_y;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    if (sum_x > ERR_BITS'(span_r)) begin
      err_x_nxt = sum_x - ERR_BITS'(span_r);
      unique case (dir_x_r)
        DIR_POS: cur_x_nxt = cur_x_r + COORD_BITS'(1);
        DIR_NEG: cur_x_nxt = cur_x_r - COORD_BITS'(1);
        default: cur_x_nxt = cur_x_r;
      endcase
    end
    if (sum_y > ERR_BITS'(span_r)) begin
      err_y_nxt = sum_y - ERR_BITS'(span_r);
      unique case (dir_y_r)
        DIR_POS: cur_y_nxt = cur_y_r + COORD_BITS'(1);
        DIR_NEG: cur_y_nxt = cur_y_r - COORD_BITS'(1);
        default: cur_y_nxt = cur_y_r;
      endcase
    end
  end

  // Result of the command being taken.
  always_comb begin
    if (cmd.start) begin
      pat_bit       = cfg.pattern[FIRST_POS];
      out_nxt.pix_x = cmd.x;
      out_nxt.pix_y = cmd.y;
    end else begin
      pat_bit       = cfg.pattern[pos_r];
      out_nxt.pix_x = cur_x_r;
      out_nxt.pix_y = cur_y_r;
    end
    out_nxt.pix_color = pat_bit ? cfg.fore : cfg.back;
    out_nxt.last      = cmd.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_take) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // Line state. A start emits its point and leaves both sums at their deltas,
  // which never exceed the span; an advance emits its point before stepping, so the point repeats.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= FIRST_POS;
    end else if (cmd_take) begin
      pos_r <= cmd.start ? FIRST_POS - POS_BITS'(1) : pos_r - POS_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      out_r <= out_nxt;
      if (cmd.start) begin
        cur_x_r <= cmd.x;
        cur_y_r <= cmd.y;
        adx_r   <= cmd.adx;
        ady_r   <= cmd.ady;
        dir_x_r <= cmd.dir_x;
        dir_y_r <= cmd.dir_y;
        span_r  <= cmd.span;
        err_x_r <= ERR_BITS'(cmd.adx);
        err_y_r <= ERR_BITS'(cmd.ady);
      end else begin
        cur_x_r <= cur_x_nxt;
        cur_y_r <= cur_y_nxt;
        err_x_r <= err_x_nxt;
        err_y_r <= err_y_nxt;
      end
    end
  end

endmodule
